FILE: hw/rtl/rounded_rect_pixel_blend_top_macros.svh
// assertion macros used by the port-level checker
`ifndef ROUNDED_RECT_PIXEL_BLEND_TOP_MACROS_SVH
`define ROUNDED_RECT_PIXEL_BLEND_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RRPB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrpb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RRPB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrpb assertion failed");

`endif

FILE: hw/rtl/rrpb_pkg.sv
// types and constants of the rounded rectangle pixel blender
package rrpb_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;

  localparam int Q_W     = 16;
  localparam int PW      = COORD_BITS + FRAC_BITS + 1;
  localparam int SW      = ((PW > Q_W + 1) ? PW : Q_W + 1) + 3;
  localparam int AW      = SW - 1;
  localparam int D2_W    = 2 * AW + 1;
  localparam int LIM_W   = Q_W + 1;
  localparam int LIMSQ_W = 2 * LIM_W;
  localparam int RAD_W   = LIMSQ_W + 32 - 2 * FRAC_BITS;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int CV_W    = ROOT_W + 2;
  localparam int AL_W    = 17;

  localparam logic [2:0] REG_RECT_X  = 3'd0;
  localparam logic [2:0] REG_RECT_Y  = 3'd1;
  localparam logic [2:0] REG_RECT_W  = 3'd2;
  localparam logic [2:0] REG_RECT_H  = 3'd3;
  localparam logic [2:0] REG_RADII   = 3'd4;
  localparam logic [2:0] REG_COLOR   = 3'd5;
  localparam logic [2:0] REG_OPACITY = 3'd6;
  localparam logic [2:0] REG_CLIP    = 3'd7;

  localparam logic [63:0] CLIP_RESET = 64'h1000_1000_0000_0000;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [7:0]            dst_red;
    logic [7:0]            dst_green;
    logic [7:0]            dst_blue;
    logic [7:0]            dst_alpha;
  } in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       written;
  } out_t;

  typedef struct packed {
    logic [7:0]     dr;
    logic [7:0]     dg;
    logic [7:0]     db;
    logic [7:0]     da;
    logic           live;
    logic           flat;
    logic           hit;
    logic           near;
    logic [Q_W-1:0] rad;
  } tag_t;

endpackage

FILE: hw/rtl/rrpb_sqrt.sv
// pipelined integer square root, one result bit per stage, tag carried along
module rrpb_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  rrpb_pkg::tag_t                   in_tag,
  input  logic [rrpb_pkg::RAD_W-1:0]       in_rad,
  output logic                             out_vld,
  output rrpb_pkg::tag_t                   out_tag,
  output logic [rrpb_pkg::ROOT_W-1:0]      out_root
);

  localparam int RW = rrpb_pkg::RAD_W;
  localparam int NW = rrpb_pkg::ROOT_W;

  logic                vld_r  [NW];
  rrpb_pkg::tag_t      tag_r  [NW];
  logic [RW-1:0]       rem_r  [NW];
  logic [NW-1:0]       root_r [NW];

  logic                vld_d  [NW];
  rrpb_pkg::tag_t      tag_d  [NW];
  logic [RW-1:0]       rem_d  [NW];
  logic [NW-1:0]       root_d [NW];

  logic [RW-1:0]       rem_nxt  [NW];
  logic [NW-1:0]       root_nxt [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    localparam int BI = NW - 1 - k;

    if (k == 0) begin : g_first
      assign vld_d[k]  = in_vld;
      assign tag_d[k]  = in_tag;
      assign rem_d[k]  = in_rad;
      assign root_d[k] = '0;
    end else begin : g_next
      assign vld_d[k]  = vld_r[k-1];
      assign tag_d[k]  = tag_r[k-1];
      assign rem_d[k]  = rem_r[k-1];
      assign root_d[k] = root_r[k-1];
    end

    always_comb begin
      logic [RW:0] trial;
      trial = ((RW+1)'(root_d[k]) << (BI + 1)) | ((RW+1)'(1) << (2 * BI));
      if ({1'b0, rem_d[k]} >= trial) begin
        rem_nxt[k]  = rem_d[k] - trial[RW-1:0];
        root_nxt[k] = root_d[k] | (NW'(1) << BI);
      end else begin
        rem_nxt[k]  = rem_d[k];
        root_nxt[k] = root_d[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_d[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k]  <= tag_d[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_tag  = tag_r[NW-1];
  assign out_root = root_r[NW-1];

endmodule

FILE: hw/rtl/rounded_rect_pixel_blend_top.sv
// top level of the rounded rectangle pixel blender
//
//   channel  ports                          direction  payload
//   in       in_valid / in_ready / in_data  input      rrpb_pkg::in_t
//   out      out_valid / out_ready/out_data output     rrpb_pkg::out_t
//   cfg      cfg_we / cfg_idx / cfg_wdata   input      64-bit register write
//
// one pixel per cycle while the output is not stalled; the path runs through the 29-stage
// square root of the corner distance, with four stages before and three after it.
// reset is synchronous, clears valid bits and sets configuration registers to reset values.
// a stalled output holds the whole pipeline; in_ready is low only then.
module rounded_rect_pixel_blend_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrpb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rrpb_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_idx,
  input  logic [63:0]    cfg_wdata
);

  localparam int SW  = rrpb_pkg::SW;
  localparam int AW  = rrpb_pkg::AW;
  localparam int FB  = rrpb_pkg::FRAC_BITS;
  localparam int QW  = rrpb_pkg::Q_W;
  localparam int ALW = rrpb_pkg::AL_W;
  localparam int CVW = rrpb_pkg::CV_W;
  localparam logic signed [SW-1:0] FHALF_S = SW'(1 << (FB - 1));
  localparam logic signed [SW-1:0] FMASK_S = SW'((1 << FB) - 1);
  localparam logic [ALW-1:0]       ONE_A   = ALW'(65536);

  // configuration
  logic [15:0] rect_x_r, rect_y_r, rect_w_r, rect_h_r;
  logic [63:0] radii_r, clip_r;
  logic [31:0] color_r;
  logic [7:0]  opacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_x_r  <= '0;
      rect_y_r  <= '0;
      rect_w_r  <= '0;
      rect_h_r  <= '0;
      radii_r   <= '0;
      color_r   <= '0;
      opacity_r <= 8'd255;
      clip_r    <= rrpb_pkg::CLIP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        rrpb_pkg::REG_RECT_X:  rect_x_r  <= cfg_wdata[15:0];
        rrpb_pkg::REG_RECT_Y:  rect_y_r  <= cfg_wdata[15:0];
        rrpb_pkg::REG_RECT_W:  rect_w_r  <= cfg_wdata[15:0];
        rrpb_pkg::REG_RECT_H:  rect_h_r  <= cfg_wdata[15:0];
        rrpb_pkg::REG_RADII:   radii_r   <= cfg_wdata;
        rrpb_pkg::REG_COLOR:   color_r   <= cfg_wdata[31:0];
        rrpb_pkg::REG_OPACITY: opacity_r <= cfg_wdata[7:0];
        rrpb_pkg::REG_CLIP:    clip_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // base alpha = floor(sa * op * 65536 / 65025), pipelined from the colour and opacity registers
  logic [15:0]    bp1_r, bp2_r, bp3_r;
  logic [24:0]    bq2_r, bq3_r;
  logic [9:0]     bt3_r;
  logic [ALW-1:0] base_a_r;
  logic [41:0]    bt_full;
  logic [24:0]    brem;

  assign bt_full = 42'(bq2_r) * 42'(66051);
  assign brem    = bq3_r - 25'(bt3_r) * 25'(65025);

  always_ff @(posedge clk) begin
    bp1_r    <= 16'(color_r[7:0]) * 16'(opacity_r);
    bp2_r    <= bp1_r;
    bq2_r    <= 25'(bp1_r) * 25'(511);
    bp3_r    <= bp2_r;
    bq3_r    <= bq2_r;
    bt3_r    <= bt_full[41:32];
    base_a_r <= ALW'(bp3_r) + ALW'(bt3_r) + ALW'(brem >= 25'(65025));
  end

  logic en;
  logic s7_vld_r;
  assign en       = !s7_vld_r || out_ready;
  assign in_ready = en;

  // stage 1: span, clip, quadrant and corner circle centre
  logic signed [SW-1:0] xs, ys, ws, hs, pxs, pys, fxs, fys;
  logic signed [SW-1:0] x0, y0, xe, ye, kx0, ky0, kx1, ky1, rq, cxq, cyq;
  logic                 left, top, span_ok, clip_ok;
  logic [1:0]           qsel;
  logic [QW-1:0]        rsel;
  rrpb_pkg::tag_t       tag1;

  always_comb begin
    xs  = SW'($signed(rect_x_r));
    ys  = SW'($signed(rect_y_r));
    ws  = $signed(SW'(rect_w_r));
    hs  = $signed(SW'(rect_h_r));
    pxs = $signed(SW'(in_data.pixel_x));
    pys = $signed(SW'(in_data.pixel_y));
    fxs = (pxs <<< FB) + FHALF_S;
    fys = (pys <<< FB) + FHALF_S;
    x0  = xs[SW-1] ? ((xs + FMASK_S) >>> FB) : (xs >>> FB);
    y0  = ys[SW-1] ? ((ys + FMASK_S) >>> FB) : (ys >>> FB);
    xe  = (xs + ws + FMASK_S) >>> FB;
    ye  = (ys + hs + FMASK_S) >>> FB;
    kx0 = $signed(SW'(clip_r[15:0]));
    ky0 = $signed(SW'(clip_r[31:16]));
    kx1 = $signed(SW'(clip_r[47:32]));
    ky1 = $signed(SW'(clip_r[63:48]));
    span_ok = (pxs >= x0) && (pxs < xe) && (pys >= y0) && (pys < ye);
    clip_ok = (pxs >= kx0) && (pxs < kx1) && (pys >= ky0) && (pys < ky1);
    left = (fxs <<< 1) < ((xs <<< 1) + ws);
    top  = (fys <<< 1) < ((ys <<< 1) + hs);
    if (top) begin
      qsel = left ? 2'd0 : 2'd1;
    end else begin
      qsel = left ? 2'd3 : 2'd2;
    end
    rsel = radii_r[16*qsel +: 16];
    rq   = $signed(SW'(rsel));
    cxq  = left ? (xs + rq) : (xs + ws - rq);
    cyq  = top ? (ys + rq) : (ys + hs - rq);
    tag1.dr   = in_data.dst_red;
    tag1.dg   = in_data.dst_green;
    tag1.db   = in_data.dst_blue;
    tag1.da   = in_data.dst_alpha;
    tag1.live = (color_r[7:0] != 8'd0) && (opacity_r != 8'd0) && span_ok && clip_ok;
    tag1.flat = (radii_r == 64'd0);
    tag1.hit  = 1'b0;
    tag1.near = 1'b0;
    tag1.rad  = rsel;
  end

  logic                 s1_vld_r, s1_left_r, s1_top_r;
  rrpb_pkg::tag_t       s1_tag_r;
  logic signed [SW-1:0] s1_fx_r, s1_fy_r, s1_cx_r, s1_cy_r;

  // stage 2: offsets from the circle centre, corner hit flag and distance limit
  logic signed [SW-1:0] dx, dy;
  logic [AW-1:0]        ax, ay;
  rrpb_pkg::tag_t       tag2;
  logic [rrpb_pkg::LIM_W-1:0] lim2;

  always_comb begin
    dx = s1_fx_r - s1_cx_r;
    dy = s1_fy_r - s1_cy_r;
    ax = dx[SW-1] ? AW'(-dx) : AW'(dx);
    ay = dy[SW-1] ? AW'(-dy) : AW'(dy);
    tag2     = s1_tag_r;
    tag2.hit = (s1_tag_r.rad != '0)
               && (s1_left_r ? (dx < 0) : (dx > 0))
               && (s1_top_r ? (dy < 0) : (dy > 0));
    lim2 = rrpb_pkg::LIM_W'(s1_tag_r.rad) + rrpb_pkg::LIM_W'(1 << (FB - 1));
  end

  logic                       s2_vld_r;
  rrpb_pkg::tag_t             s2_tag_r;
  logic [AW-1:0]              s2_ax_r, s2_ay_r;
  logic [rrpb_pkg::LIM_W-1:0] s2_lim_r;

  // stage 3: squares
  logic                         s3_vld_r;
  rrpb_pkg::tag_t               s3_tag_r;
  logic [2*AW-1:0]              s3_sqx_r, s3_sqy_r;
  logic [rrpb_pkg::LIMSQ_W-1:0] s3_limsq_r;

  // stage 4: squared distance, near flag and radicand
  logic [rrpb_pkg::D2_W-1:0] d2;
  rrpb_pkg::tag_t            tag4;
  logic                      s4_vld_r;
  rrpb_pkg::tag_t            s4_tag_r;
  logic [rrpb_pkg::RAD_W-1:0] s4_rad_r;

  always_comb begin
    d2 = rrpb_pkg::D2_W'(s3_sqx_r) + rrpb_pkg::D2_W'(s3_sqy_r);
    tag4      = s3_tag_r;
    tag4.near = d2 < rrpb_pkg::D2_W'(s3_limsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r   <= tag1;
      s1_left_r  <= left;
      s1_top_r   <= top;
      s1_fx_r    <= fxs;
      s1_fy_r    <= fys;
      s1_cx_r    <= cxq;
      s1_cy_r    <= cyq;
      s2_tag_r   <= tag2;
      s2_ax_r    <= ax;
      s2_ay_r    <= ay;
      s2_lim_r   <= lim2;
      s3_tag_r   <= s2_tag_r;
      s3_sqx_r   <= (2*AW)'(s2_ax_r) * (2*AW)'(s2_ax_r);
      s3_sqy_r   <= (2*AW)'(s2_ay_r) * (2*AW)'(s2_ay_r);
      s3_limsq_r <= rrpb_pkg::LIMSQ_W'(s2_lim_r) * rrpb_pkg::LIMSQ_W'(s2_lim_r);
      s4_tag_r   <= tag4;
      s4_rad_r   <= {d2[rrpb_pkg::LIMSQ_W-1:0],
                     (rrpb_pkg::RAD_W - rrpb_pkg::LIMSQ_W)'(0)};
    end
  end

  logic                        sq_vld;
  rrpb_pkg::tag_t              sq_tag;
  logic [rrpb_pkg::ROOT_W-1:0] sq_root;

  rrpb_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s4_vld_r),
    .in_tag   (s4_tag_r),
    .in_rad   (s4_rad_r),
    .out_vld  (sq_vld),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  // stage 5: coverage
  logic signed [CVW-1:0] cval;
  logic [ALW-1:0]        cov5, clamp5;
  rrpb_pkg::tag_t        tag5;

  always_comb begin
    cval = ($signed(CVW'(sq_tag.rad)) <<< (16 - FB)) + $signed(CVW'(32768))
           - $signed(CVW'(sq_root));
    if (cval < 0) begin
      clamp5 = '0;
    end else if (cval > $signed(CVW'(65536))) begin
      clamp5 = ONE_A;
    end else begin
      clamp5 = cval[ALW-1:0];
    end
    if (!sq_tag.hit) begin
      cov5 = ONE_A;
    end else if (!sq_tag.near) begin
      cov5 = '0;
    end else begin
      cov5 = clamp5;
    end
    tag5      = sq_tag;
    tag5.live = sq_tag.live && (sq_tag.flat || (cov5 != '0));
  end

  logic           s5_vld_r, s6_vld_r;
  rrpb_pkg::tag_t s5_tag_r, s6_tag_r;
  logic [ALW-1:0] s5_cov_r, s6_a_r;
  logic [2*ALW-1:0] acov;

  assign acov = (2*ALW)'(base_a_r) * (2*ALW)'(s5_cov_r);

  // stage 7: blend
  logic [ALW-1:0] inva;
  logic [7:0]     inc7;
  logic [8:0]     sum7;
  logic [24:0]    prod255;
  rrpb_pkg::out_t res7, s7_out_r;

  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [ALW-1:0] a,
                                     input logic [ALW-1:0] ia);
    logic [25:0] acc;
    acc = 26'(s) * 26'(a) + 26'(d) * 26'(ia);
    return acc[23:16];
  endfunction

  always_comb begin
    inva    = ONE_A - s6_a_r;
    prod255 = 25'(s6_a_r) * 25'(255);
    inc7    = prod255[23:16];
    sum7    = 9'(s6_tag_r.da) + 9'(inc7);
    if (!s6_tag_r.live) begin
      res7.out_red   = s6_tag_r.dr;
      res7.out_green = s6_tag_r.dg;
      res7.out_blue  = s6_tag_r.db;
      res7.out_alpha = s6_tag_r.da;
      res7.written   = 1'b0;
    end else begin
      res7.out_red   = mix(color_r[31:24], s6_tag_r.dr, s6_a_r, inva);
      res7.out_green = mix(color_r[23:16], s6_tag_r.dg, s6_a_r, inva);
      res7.out_blue  = mix(color_r[15:8], s6_tag_r.db, s6_a_r, inva);
      if (s6_tag_r.flat) begin
        res7.out_alpha = sum7[8] ? 8'd255 : sum7[7:0];
      end else begin
        res7.out_alpha = mix(8'd255, s6_tag_r.da, s6_a_r, inva);
      end
      res7.written = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= sq_vld;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tag_r      <= tag5;
      s5_cov_r      <= cov5;
      s6_tag_r      <= s5_tag_r;
      s6_a_r        <= s5_tag_r.flat ? base_a_r : acov[ALW+15:16];
      s7_out_r      <= res7;
    end
  end

  assign out_valid = s7_vld_r;
  assign out_data  = s7_out_r;

endmodule

FILE: hw/rtl/rrpb_checker.sv
// port-level checker for the rounded rectangle pixel blender, bound to the top
`include "rounded_rect_pixel_blend_top_macros.svh"

module rrpb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input rrpb_pkg::out_t out_data
);

  // a stalled result transaction holds its data
  `RRPB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a free output slot always lets the pipeline take a transaction
  `RRPB_ASSERT_IMP(a_ready_when_free, !out_valid || out_ready, in_ready)

  // a stalled output freezes the input side
  `RRPB_ASSERT_IMP(a_stall_blocks_in, out_valid && !out_ready, !in_ready)

endmodule

bind rounded_rect_pixel_blend_top rrpb_checker u_rrpb_checker (.*);
